### rtl/rrts_pkg.sv
// Shared types and constants of the round-robin time-slice arbiter.
package rrts_pkg;

	localparam int ENTRIES    = 8;
	localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W      = $clog2(ENTRIES + 1);
	localparam int ID_W       = 8;
	localparam int TIME_W     = 12;
	localparam int SLICE_W    = 8;
	localparam int SLICE_RST  = 5;
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W     = $clog2(QDEPTH + 1);

	typedef enum logic [0:0] {
		OP_LOAD = 1'b0,
		OP_TICK = 1'b1
	} rrts_op_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_SCAN
	} rrts_state_t;

	typedef struct packed {
		rrts_op_t            op;
		logic [ID_W-1:0]     id;
		logic [TIME_W-1:0]   need;
	} rrts_item_t;

	typedef struct packed {
		logic [ID_W-1:0] granted_id;
		logic            grant_valid;
		logic            all_done;
		logic            load_accepted;
	} rrts_res_t;

endpackage

### rtl/rrts_if.sv
// Valid/ready channel interfaces for requests and results.
interface rrts_req_if;
	logic        valid;
	logic        ready;
	logic [0:0]  req_type;
	logic [7:0]  requester_id;
	logic [11:0] time_needed;

	modport source (output valid, output req_type, output requester_id,
		output time_needed, input ready);
	modport sink (input valid, input req_type, input requester_id,
		input time_needed, output ready);
endinterface

interface rrts_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] granted_id;
	logic       grant_valid;
	logic       all_done;
	logic       load_accepted;

	modport source (output valid, output granted_id, output grant_valid,
		output all_done, output load_accepted, input ready);
	modport sink (input valid, input granted_id, input grant_valid,
		input all_done, input load_accepted, output ready);
	modport mon (input valid, input ready, input granted_id, input grant_valid,
		input all_done, input load_accepted);
endinterface

### rtl/rrts_front.sv
// Front end: slice register, request decode and push into the queue.
module rrts_front (
	input  logic                          clk,
	input  logic                          arst_n,
	rrts_req_if.sink                      req,
	input  logic                          cfg_we,
	input  logic [rrts_pkg::SLICE_W-1:0]  cfg_wdata,
	input  logic                          q_full,
	output logic                          q_push,
	output rrts_pkg::rrts_item_t          q_item,
	output logic [rrts_pkg::SLICE_W-1:0]  slice
);
	import rrts_pkg::*;

	logic [SLICE_W-1:0] slice_q;
	rrts_op_t           op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_q <= SLICE_W'(SLICE_RST);
		end else if (cfg_we) begin
			slice_q <= cfg_wdata;
		end
	end

	// a zero slice counts as one time unit
	assign slice = (slice_q == '0) ? SLICE_W'(1) : slice_q;

	always_comb begin
		unique case (req.req_type)
			1'b0:    op = OP_LOAD;
			1'b1:    op = OP_TICK;
			default: op = OP_TICK;
		endcase
	end

	assign req.ready   = !q_full;
	assign q_push      = req.valid && !q_full;
	assign q_item.op   = op;
	assign q_item.id   = req.requester_id;
	assign q_item.need = req.time_needed;

endmodule

### rtl/rrts_queue.sv
// Short FIFO of decoded items between front and back end.
module rrts_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  rrts_pkg::rrts_item_t push_item,
	output logic                 full,
	input  logic                 pop,
	output logic                 valid,
	output rrts_pkg::rrts_item_t head
);
	import rrts_pkg::*;

	rrts_item_t        mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		ptr_next = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	assign full  = (cnt_q == QCNT_W'(QDEPTH));
	assign valid = (cnt_q != '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

### rtl/rrts_back.sv
// Back end: request table, cyclic scan for grants and result register.
module rrts_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  rrts_pkg::rrts_item_t          q_item,
	output logic                          q_pop,
	input  logic [rrts_pkg::SLICE_W-1:0]  slice,
	rrts_rsp_if.source                    rsp
);
	import rrts_pkg::*;

	logic [ID_W-1:0]   own_q [ENTRIES];
	logic [TIME_W-1:0] rem_q [ENTRIES];

	rrts_state_t       state_q, state_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [IDX_W-1:0]  pos_q, pos_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic [CNT_W-1:0]  k_q, k_d;

	logic              out_valid_q;
	rrts_res_t         res_q, res_d;
	logic              res_we;
	logic              out_free;
	logic              load_we;
	logic              rem_we;
	logic [TIME_W-1:0] slice_ext;
	logic [TIME_W-1:0] rem_cur;

	assign out_free  = !out_valid_q || rsp.ready;
	assign slice_ext = TIME_W'(slice);
	assign rem_cur   = rem_q[idx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		q_pop   = 1'b0;
		res_we  = 1'b0;
		res_d   = '0;
		load_we = 1'b0;
		rem_we  = 1'b0;
		cnt_d   = cnt_q;
		pos_d   = pos_q;
		idx_d   = idx_q;
		k_d     = k_q;
		unique case (state_q)
			ST_IDLE: begin
				// take an item only when its result has a free slot to land in
				if (q_valid && out_free) begin
					q_pop = 1'b1;
					if (q_item.op == OP_LOAD) begin
						res_we = 1'b1;
						if (cnt_q < CNT_W'(ENTRIES)) begin
							load_we             = 1'b1;
							cnt_d               = cnt_q + CNT_W'(1);
							res_d.load_accepted = 1'b1;
						end
					end else if (cnt_q == '0) begin
						res_we         = 1'b1;
						res_d.all_done = 1'b1;
						pos_d          = '0;
					end else begin
						state_d = ST_SCAN;
						k_d     = '0;
						idx_d   = (CNT_W'(pos_q) < cnt_q) ? pos_q : '0;
					end
				end
			end
			ST_SCAN: begin
				if (rem_cur >= slice_ext) begin
					rem_we            = 1'b1;
					res_we            = 1'b1;
					res_d.granted_id  = own_q[idx_q];
					res_d.grant_valid = 1'b1;
					pos_d   = (idx_q == IDX_W'(ENTRIES - 1)) ? '0 : idx_q + IDX_W'(1);
					state_d = ST_IDLE;
				end else if (k_q + CNT_W'(1) == cnt_q) begin
					// no live entry left: empty the table
					res_we         = 1'b1;
					res_d.all_done = 1'b1;
					cnt_d          = '0;
					pos_d          = '0;
					state_d        = ST_IDLE;
				end else begin
					k_d   = k_q + CNT_W'(1);
					idx_d = (CNT_W'(idx_q) + CNT_W'(1) == cnt_q) ? '0 : idx_q + IDX_W'(1);
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			pos_q       <= '0;
			idx_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			pos_q <= pos_d;
			idx_q <= idx_d;
			k_q   <= k_d;
			if (res_we) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_we) begin
			res_q <= res_d;
		end
		if (load_we) begin
			own_q[cnt_q[IDX_W-1:0]] <= q_item.id;
			rem_q[cnt_q[IDX_W-1:0]] <= q_item.need;
		end
		if (rem_we) begin
			rem_q[idx_q] <= rem_cur - slice_ext;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.granted_id    = res_q.granted_id;
	assign rsp.grant_valid   = res_q.grant_valid;
	assign rsp.all_done      = res_q.all_done;
	assign rsp.load_accepted = res_q.load_accepted;

endmodule

### rtl/round_robin_time_slice_arbiter_unit.sv
// Round-robin time-slice bus arbiter: top level.
//
// Channels: req carries one transaction per item (req_type 0 loads a request
// of requester_id needing time_needed units, req_type 1 is a grant tick); rsp
// returns exactly one result per item, in order. cfg_we/cfg_wdata write the
// slice length (reset 5, zero acts as one); the user must write it only while
// the block is idle, which the block itself does not enforce. A two-entry
// queue separates the decode front end from the table back end, so requests
// are still accepted while a result waits on rsp, until the queue fills.
// A load result is registered; a tick result is registered once the scan,
// reading one table slot per cycle, finds a grant or has seen every slot;
// no item is popped meanwhile. One load per cycle is taken while rsp flows.
// Reset clears the table count, scan position, queue and result valid flag;
// the slice length returns to 5. Table contents are not cleared.
// When rsp stalls, the result holds on rsp, the back end stops taking items,
// the queue fills and req.ready drops.
module round_robin_time_slice_arbiter_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	rrts_req_if.sink                      req,
	rrts_rsp_if.source                    rsp,
	input  logic                          cfg_we,
	input  logic [rrts_pkg::SLICE_W-1:0]  cfg_wdata
);
	import rrts_pkg::*;

	logic               q_full;
	logic               q_push;
	logic               q_pop;
	logic               q_valid;
	rrts_item_t         push_item;
	rrts_item_t         head;
	logic [SLICE_W-1:0] slice;

	rrts_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (push_item),
		.slice     (slice)
	);

	rrts_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (head)
	);

	rrts_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (head),
		.q_pop   (q_pop),
		.slice   (slice),
		.rsp     (rsp)
	);

endmodule

### rtl/rrts_chk.sv
// Port-level checks on the arbiter result channel, bound to the top level.
module rrts_chk (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       rsp_valid,
	input  logic       rsp_ready,
	input  logic [7:0] granted_id,
	input  logic       grant_valid,
	input  logic       all_done,
	input  logic       load_accepted
);

	// a result carries at most one kind of outcome
	a_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $onehot0({grant_valid, all_done, load_accepted}))
		else $error("result flags more than one outcome");

	// no requester number without a grant
	a_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !grant_valid) |-> (granted_id == 8'd0))
		else $error("granted_id set on a result without a grant");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> rsp_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> ($stable(granted_id) && $stable(grant_valid)
			&& $stable(all_done) && $stable(load_accepted)))
		else $error("result changed while stalled");

endmodule

bind round_robin_time_slice_arbiter_unit rrts_chk u_rrts_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.granted_id    (rsp.granted_id),
	.grant_valid   (rsp.grant_valid),
	.all_done      (rsp.all_done),
	.load_accepted (rsp.load_accepted)
);

### verif/tb_round_robin_time_slice_arbiter_unit.sv
`timescale 1ns / 1ps
// Testbench for the round-robin time-slice arbiter: directed table, random bursts, grant predictor.
module tb_round_robin_time_slice_arbiter_unit;
	import rrts_pkg::*;

	localparam int HOLD_CYCLES    = 80;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = ENTRIES + 4;
	localparam int PHASE_ITEMS    = 120;
	localparam int NUM_PHASES     = 6;

	typedef struct {
		rrts_item_t item;
		bit         typed;
		rrts_res_t  res;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we;
	logic [SLICE_W-1:0] cfg_wdata;

	rrts_req_if req_ch();
	rrts_rsp_if rsp_ch();

	round_robin_time_slice_arbiter_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// arbiter state as the predictor sees it
	logic [ID_W-1:0]    owner_m [ENTRIES];
	logic [TIME_W-1:0]  left_m [ENTRIES];
	int                 count_m = 0;
	int                 scan_m = 0;
	logic [SLICE_W-1:0] slice_m = SLICE_RST[SLICE_W-1:0];

	rrts_res_t grant_q[$];
	stim_row_t dir_rows[$];
	bit        typed_en = 1'b0;
	rrts_res_t typed_res = '0;
	bit        quiet = 1'b0;
	bit        hold_req = 1'b0;
	int        hold_left = 0;
	int        errors = 0;
	int        stall_cycles = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 0;
	end

	function automatic rrts_res_t predict_grant(rrts_item_t it);
		rrts_res_t r;
		int slice;
		int start;
		int idx;
		int k;
		r = '0;
		if (it.op == OP_LOAD) begin
			if (count_m < ENTRIES) begin
				owner_m[count_m] = it.id;
				left_m[count_m] = it.need;
				count_m++;
				r.load_accepted = 1'b1;
			end
			return r;
		end
		slice = (slice_m == 0) ? 1 : int'(slice_m);
		// wrap to slot 0 when the scan start lies past the occupied slots
		start = (scan_m < count_m) ? scan_m : 0;
		for (k = 0; k < count_m; k++) begin
			idx = start + k;
			if (idx >= count_m)
				idx -= count_m;
			if (int'(left_m[idx]) >= slice) begin
				left_m[idx] = left_m[idx] - TIME_W'(slice);
				r.granted_id = owner_m[idx];
				r.grant_valid = 1'b1;
				scan_m = (idx + 1 < ENTRIES) ? idx + 1 : 0;
				return r;
			end
		end
		count_m = 0;
		scan_m = 0;
		r.all_done = 1'b1;
		return r;
	endfunction

	function automatic void add_row(rrts_op_t op, int id, int need, bit typed,
			int gid, bit gv, bit done, bit acc);
		stim_row_t row;
		row.item.op = op;
		row.item.id = ID_W'(id);
		row.item.need = TIME_W'(need);
		row.typed = typed;
		row.res.granted_id = ID_W'(gid);
		row.res.grant_valid = gv;
		row.res.all_done = done;
		row.res.load_accepted = acc;
		dir_rows = {dir_rows, row};
	endfunction

	function automatic rrts_item_t make_item(rrts_op_t op);
		rrts_item_t it;
		int top;
		it.op = op;
		it.id = ID_W'($urandom_range(255));
		top = (slice_m == 0) ? 4 : 4 * int'(slice_m);
		// keep most requests within four slices so the table drains
		if (slice_m >= 128 && $urandom_range(99) < 10)
			it.need = TIME_W'($urandom_range(4095));
		else
			it.need = TIME_W'($urandom_range(top));
		return it;
	endfunction

	always @(posedge clk) begin : monitor
		rrts_item_t it;
		rrts_res_t  pred;
		rrts_res_t  want;
		rrts_res_t  got;
		if (cfg_we)
			slice_m = cfg_wdata;
		if (req_ch.valid && req_ch.ready) begin
			it.op = rrts_op_t'(req_ch.req_type);
			it.id = req_ch.requester_id;
			it.need = req_ch.time_needed;
			pred = predict_grant(it);
			if (typed_en)
				pred = typed_res;
			grant_q = {grant_q, pred};
		end
		if (rsp_ch.valid && rsp_ch.ready) begin
			got.granted_id = rsp_ch.granted_id;
			got.grant_valid = rsp_ch.grant_valid;
			got.all_done = rsp_ch.all_done;
			got.load_accepted = rsp_ch.load_accepted;
			if (grant_q.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual id=%0d grant=%0b",
					$time, got.granted_id, got.grant_valid,
					" done=%0b accepted=%0b", got.all_done, got.load_accepted);
				errors++;
			end else begin
				want = grant_q.pop_front();
				if (got !== want) begin
					$display("%0t: result mismatch: expected id=%0d grant=%0b done=%0b",
						$time, want.granted_id, want.grant_valid, want.all_done,
						" accepted=%0b, actual id=%0d grant=%0b done=%0b accepted=%0b",
						want.load_accepted, got.granted_id, got.grant_valid,
						got.all_done, got.load_accepted);
					errors++;
				end
			end
		end
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, stall_cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// result receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= quiet || ($urandom_range(99) >= 15);
		end
	end

	// call at a falling edge; returns at the falling edge after acceptance
	task automatic send_item(rrts_item_t it, bit with_typed, rrts_res_t res);
		if (!quiet) begin
			while ($urandom_range(99) < 15) begin
				req_ch.valid <= 1'b0;
				@(negedge clk);
			end
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= it.op;
		req_ch.requester_id <= it.id;
		req_ch.time_needed <= it.need;
		typed_en <= with_typed;
		typed_res <= res;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (grant_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_slice(logic [SLICE_W-1:0] value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// tick until the table reports done
	task automatic drain_table();
		while (count_m != 0)
			send_item(make_item(OP_TICK), 1'b0, '0);
	endtask

	initial begin : stimulus
		logic [SLICE_W-1:0] phase_slice [NUM_PHASES];
		int  n;
		int  nl;
		int  nt;
		bit  held;
		bit  paused;
		req_ch.valid = 1'b0;
		req_ch.req_type = OP_LOAD;
		req_ch.requester_id = '0;
		req_ch.time_needed = '0;
		rsp_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		held = 1'b0;
		paused = 1'b0;
		phase_slice = '{8'd255, 8'd0, 8'd1, 8'd3, SLICE_W'($urandom_range(2, 254)),
			SLICE_W'(SLICE_RST)};

		// slice length is 5 out of reset
		add_row(OP_TICK, 8'h00, 0, 1, 0, 0, 1, 0);       // empty table
		add_row(OP_LOAD, 8'h00, 0, 1, 0, 0, 0, 1);       // never granted
		add_row(OP_LOAD, 8'hff, 4095, 1, 0, 0, 0, 1);
		add_row(OP_LOAD, 8'ha5, 5, 1, 0, 0, 0, 1);
		add_row(OP_LOAD, 8'h5a, 9, 1, 0, 0, 0, 1);
		add_row(OP_TICK, 8'h00, 0, 1, 8'hff, 1, 0, 0);
		add_row(OP_TICK, 8'h00, 0, 1, 8'ha5, 1, 0, 0);
		add_row(OP_TICK, 8'h00, 0, 1, 8'h5a, 1, 0, 0);
		add_row(OP_TICK, 8'h00, 0, 0, 0, 0, 0, 0);       // scan wraps to slot 0
		add_row(OP_LOAD, 8'h01, 12'h800, 1, 0, 0, 0, 1);
		add_row(OP_LOAD, 8'h02, 12'h555, 1, 0, 0, 0, 1);
		add_row(OP_LOAD, 8'h03, 12'h2aa, 1, 0, 0, 0, 1);
		add_row(OP_LOAD, 8'h04, 4, 1, 0, 0, 0, 1);
		add_row(OP_LOAD, 8'h7f, 100, 1, 0, 0, 0, 0);     // table full
		add_row(OP_TICK, 8'h00, 0, 0, 0, 0, 0, 0);
		add_row(OP_TICK, 8'h00, 0, 0, 0, 0, 0, 0);
		add_row(OP_TICK, 8'h00, 0, 0, 0, 0, 0, 0);
		add_row(OP_TICK, 8'h00, 0, 0, 0, 0, 0, 0);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_slice(phase_slice[p]);
			quiet = (p == 3);
			n = 0;
			while (n < PHASE_ITEMS) begin
				if ($urandom_range(99) < 80) begin
					nl = $urandom_range(1, ENTRIES + 1);
					nt = $urandom_range(1, 3 * ENTRIES);
					repeat (nl) send_item(make_item(OP_LOAD), 1'b0, '0);
					repeat (nt) send_item(make_item(OP_TICK), 1'b0, '0);
					n += nl + nt;
				end else begin
					send_item(make_item(rrts_op_t'($urandom_range(1))), 1'b0, '0);
					n++;
				end
				// stall the result side while requests keep coming
				if (p == 0 && !held && n >= 40) begin
					hold_req = 1'b1;
					held = 1'b1;
				end
				if (p == 1 && !paused && n >= 70) begin
					wait_drained();
					paused = 1'b1;
				end
			end
			drain_table();
			quiet = 1'b0;
		end

		wait_drained();
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### filelist.f
rtl/rrts_pkg.sv
rtl/rrts_if.sv
rtl/rrts_front.sv
rtl/rrts_queue.sv
rtl/rrts_back.sv
rtl/round_robin_time_slice_arbiter_unit.sv
rtl/rrts_chk.sv
verif/tb_round_robin_time_slice_arbiter_unit.sv
